// ===== rtl/core/mlr_pkg.sv =====
// Shared types and constants of the midpoint line rasterizer.
// Holds the frame geometry, the request and response words and the controller interface.
// Depends on nothing.
`timescale 1ns / 1ps

package mlr_pkg;

   // Frame store geometry.
   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int ADDR_W      = COL_W + ROW_W;
   localparam int FRAME_DEPTH = 1 << ADDR_W;

   // Word field widths.
   localparam int COORD_W  = 12;
   localparam int RD_POS_W = 8;
   localparam int CFG_W    = 9;

   // Compare width for clipping: holds any nonnegative coordinate and the store size.
   localparam int CMP_W = COORD_W + 1;
   localparam logic [CMP_W-1:0] MAX_W_CMP = CMP_W'(MAX_WIDTH);
   localparam logic [CMP_W-1:0] MAX_H_CMP = CMP_W'(MAX_HEIGHT);

   // Register port.
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;
   localparam logic [CFG_W-1:0] ACTIVE_SIZE_RESET = 9'd256;

   typedef enum logic {
      REG_ACTIVE_WIDTH  = 1'b0,
      REG_ACTIVE_HEIGHT = 1'b1
   } reg_index_type;

   typedef enum logic {
      CMD_DRAW = 1'b0,
      CMD_READ = 1'b1
   } cmd_code_type;

   typedef struct packed {
      logic                       cmd;
      logic signed [COORD_W-1:0]  x_start;
      logic signed [COORD_W-1:0]  y_start;
      logic signed [COORD_W-1:0]  x_end;
      logic signed [COORD_W-1:0]  y_end;
      logic [RD_POS_W-1:0]        read_col;
      logic [RD_POS_W-1:0]        read_row;
   } req_type;

   typedef struct packed {
      logic is_read_reply;
      logic pixel_lit;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic load;
      logic setup;
      logic step;
      logic draw_done;
      logic read_reply;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic step_last;
      logic is_read;
   } dp_status_type;

endpackage

// ===== rtl/core/mlr_frame_store.sv =====
// One-bit-per-pixel frame store of the line rasterizer.
// One write port and one registered read port; uses mlr_pkg for the geometry.
`timescale 1ns / 1ps

module mlr_frame_store
   import mlr_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic              wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic              rd_data
);

   logic frame_ff [FRAME_DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= frame_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/mlr_ctrl.sv =====
// Controller state machine of the line rasterizer.
// Sequences clearing, command setup, pixel stepping and replies; uses mlr_pkg.
`timescale 1ns / 1ps

module mlr_ctrl
   import mlr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          busy
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_SETUP = 5'b00100,
      ST_STEP  = 5'b01000,
      ST_REPLY = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = status.is_read ? ST_REPLY : ST_STEP;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            if (status.step_last) begin
               cmd.draw_done = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_REPLY: begin
            cmd.read_reply = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== rtl/core/mlr_datapath.sv =====
// Datapath of the line rasterizer: endpoint registers, octant setup, decision stepper,
// clipping, clear sweep and the response register. Uses mlr_pkg.
`timescale 1ns / 1ps

module mlr_datapath
   import mlr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ctrl_cmd_type      cmd,
   output dp_status_type     status,
   input  req_type           req_data,
   input  logic [CFG_W-1:0]  active_width,
   input  logic [CFG_W-1:0]  active_height,
   output logic              mem_wr_en,
   output logic [ADDR_W-1:0] mem_wr_addr,
   output logic              mem_wr_data,
   output logic              mem_rd_en,
   output logic [ADDR_W-1:0] mem_rd_addr,
   input  logic              mem_rd_data,
   output logic              rsp_strobe,
   output rsp_type           rsp_data
);

   // Twice the midpoint decision value stays well inside this width.
   localparam int D_W = 16;

   typedef enum logic [2:0] {
      OCT_1 = 3'd0,
      OCT_2 = 3'd1,
      OCT_3 = 3'd2,
      OCT_4 = 3'd3,
      OCT_5 = 3'd4,
      OCT_6 = 3'd5,
      OCT_7 = 3'd6,
      OCT_8 = 3'd7
   } octant_type;

   // When the minor axis takes a step, judged on the decision value.
   typedef enum logic [1:0] {
      COND_GT    = 2'd0,
      COND_LT    = 2'd1,
      COND_LE    = 2'd2,
      COND_NEVER = 2'd3
   } cond_type;

   logic                       is_read_ff;
   logic [ADDR_W-1:0]          rd_addr_ff;
   logic                       rd_ok_ff;
   logic signed [COORD_W-1:0]  x_ff;
   logic signed [COORD_W-1:0]  y_ff;
   logic signed [COORD_W:0]    dx_ff;
   logic signed [COORD_W:0]    dy_ff;
   logic signed [D_W-1:0]      d_ff;
   logic signed [D_W-1:0]      inc_s_ff;
   logic signed [D_W-1:0]      inc_d_ff;
   cond_type                   cond_ff;
   logic                       x_major_ff;
   logic                       x_neg_ff;
   logic                       y_neg_ff;
   logic [COORD_W-1:0]         cnt_ff;
   logic [ADDR_W-1:0]          clr_ff;
   logic                       rsp_strobe_ff;
   rsp_type                    rsp_ff;

   // Load: read address and clip flag.
   logic [CMP_W-1:0]  rd_col_cmp;
   logic [CMP_W-1:0]  rd_row_cmp;
   logic [ADDR_W-1:0] rd_addr_in;
   logic              rd_ok_in;

   assign rd_col_cmp = {{(CMP_W-RD_POS_W){1'b0}}, req_data.read_col};
   assign rd_row_cmp = {{(CMP_W-RD_POS_W){1'b0}}, req_data.read_row};
   assign rd_addr_in = {rd_row_cmp[ROW_W-1:0], rd_col_cmp[COL_W-1:0]};
   assign rd_ok_in   = (rd_col_cmp < MAX_W_CMP) && (rd_row_cmp < MAX_H_CMP);

   // Setup: octant, initial decision value and its two increments.
   logic signed [COORD_W:0] ax;
   logic signed [COORD_W:0] ay;
   logic [COORD_W-1:0]      ax_u;
   logic [COORD_W-1:0]      ay_u;
   logic                    dx_neg;
   logic                    dy_neg;
   logic                    dx_zero;
   logic                    dy_zero;
   logic                    x_major;
   logic signed [D_W-1:0]   dxw;
   logic signed [D_W-1:0]   dyw;
   logic signed [D_W-1:0]   dx2;
   logic signed [D_W-1:0]   dy2;
   octant_type              oct;
   logic signed [D_W-1:0]   d_init;
   logic signed [D_W-1:0]   inc_s_init;
   logic signed [D_W-1:0]   inc_d_init;
   cond_type                cond_init;
   logic                    x_major_init;
   logic [COORD_W-1:0]      cnt_init;

   assign dx_neg  = dx_ff[COORD_W];
   assign dy_neg  = dy_ff[COORD_W];
   assign dx_zero = (dx_ff == '0);
   assign dy_zero = (dy_ff == '0);
   assign ax      = dx_neg ? -dx_ff : dx_ff;
   assign ay      = dy_neg ? -dy_ff : dy_ff;
   assign ax_u    = ax[COORD_W-1:0];
   assign ay_u    = ay[COORD_W-1:0];
   assign x_major = (ax_u >= ay_u);
   assign dxw     = {{(D_W-COORD_W-1){dx_ff[COORD_W]}}, dx_ff};
   assign dyw     = {{(D_W-COORD_W-1){dy_ff[COORD_W]}}, dy_ff};
   assign dx2     = {dxw[D_W-2:0], 1'b0};
   assign dy2     = {dyw[D_W-2:0], 1'b0};

   always_comb begin
      priority if (!dx_neg && !dy_neg) begin
         oct = x_major ? OCT_1 : OCT_2;
      end else if (dx_neg && !dy_neg) begin
         oct = x_major ? OCT_4 : OCT_3;
      end else if (dx_neg) begin
         oct = x_major ? OCT_5 : OCT_6;
      end else begin
         oct = x_major ? OCT_8 : OCT_7;
      end
   end

   always_comb begin
      unique case (oct)
         OCT_1: begin
            d_init = dy2 - dxw;  inc_s_init = dy2;  inc_d_init = dy2 - dx2;
            cond_init = COND_GT;
         end
         OCT_2: begin
            d_init = dyw - dx2;  inc_s_init = -dx2; inc_d_init = dy2 - dx2;
            cond_init = COND_LT;
         end
         OCT_3: begin
            d_init = -dyw - dx2; inc_s_init = -dx2; inc_d_init = -(dy2 + dx2);
            cond_init = COND_GT;
         end
         OCT_4: begin
            d_init = -dy2 - dxw; inc_s_init = -dy2; inc_d_init = -(dy2 + dx2);
            cond_init = COND_LT;
         end
         OCT_5: begin
            d_init = dxw - dy2;  inc_s_init = -dy2; inc_d_init = dx2 - dy2;
            cond_init = COND_GT;
         end
         OCT_6: begin
            d_init = dx2 - dyw;  inc_s_init = dx2;  inc_d_init = dx2 - dy2;
            cond_init = COND_LE;
         end
         OCT_7: begin
            d_init = dyw + dx2;  inc_s_init = dx2;  inc_d_init = dy2 + dx2;
            cond_init = COND_GT;
         end
         OCT_8: begin
            d_init = dy2 + dxw;  inc_s_init = dy2;  inc_d_init = dy2 + dx2;
            cond_init = COND_LT;
         end
         default: begin
            d_init = '0;  inc_s_init = '0;  inc_d_init = '0;
            cond_init = COND_NEVER;
         end
      endcase
      x_major_init = x_major;
      // Horizontal and vertical lines walk straight along their one axis.
      if (dy_zero) begin
         cond_init    = COND_NEVER;
         x_major_init = 1'b1;
      end else if (dx_zero) begin
         cond_init    = COND_NEVER;
         x_major_init = 1'b0;
      end
      cnt_init = x_major_init ? ax_u : ay_u;
   end

   // Step: choose straight or diagonal, move, update the decision value.
   logic                      d_pos;
   logic                      d_neg;
   logic                      d_zero;
   logic                      diag;
   logic                      x_move;
   logic                      y_move;
   logic signed [COORD_W-1:0] x_delta;
   logic signed [COORD_W-1:0] y_delta;
   logic signed [COORD_W-1:0] x_next;
   logic signed [COORD_W-1:0] y_next;
   logic signed [D_W-1:0]     d_next;

   assign d_neg  = d_ff[D_W-1];
   assign d_zero = (d_ff == '0);
   assign d_pos  = !d_neg && !d_zero;

   always_comb begin
      unique case (cond_ff)
         COND_GT:    diag = d_pos;
         COND_LT:    diag = d_neg;
         COND_LE:    diag = d_neg || d_zero;
         COND_NEVER: diag = 1'b0;
         default:    diag = 1'b0;
      endcase
   end

   assign x_move  = x_major_ff || diag;
   assign y_move  = !x_major_ff || diag;
   assign x_delta = x_neg_ff ? {COORD_W{1'b1}} : COORD_W'(1);
   assign y_delta = y_neg_ff ? {COORD_W{1'b1}} : COORD_W'(1);
   assign x_next  = x_move ? x_ff + x_delta : x_ff;
   assign y_next  = y_move ? y_ff + y_delta : y_ff;
   assign d_next  = d_ff + (diag ? inc_d_ff : inc_s_ff);

   // Clipping of the current pixel.
   logic [CMP_W-1:0] x_cmp;
   logic [CMP_W-1:0] y_cmp;
   logic [CMP_W-1:0] aw_cmp;
   logic [CMP_W-1:0] ah_cmp;
   logic             in_bounds;

   assign x_cmp     = {1'b0, x_ff};
   assign y_cmp     = {1'b0, y_ff};
   assign aw_cmp    = {{(CMP_W-CFG_W){1'b0}}, active_width};
   assign ah_cmp    = {{(CMP_W-CFG_W){1'b0}}, active_height};
   assign in_bounds = !x_ff[COORD_W-1] && !y_ff[COORD_W-1]
                      && (x_cmp < aw_cmp) && (x_cmp < MAX_W_CMP)
                      && (y_cmp < ah_cmp) && (y_cmp < MAX_H_CMP);

   // Store ports: the clear sweep owns the write port after reset.
   always_comb begin
      if (cmd.clear) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_ff;
         mem_wr_data = 1'b0;
      end else begin
         mem_wr_en   = cmd.step && in_bounds;
         mem_wr_addr = {y_cmp[ROW_W-1:0], x_cmp[COL_W-1:0]};
         mem_wr_data = 1'b1;
      end
   end

   assign mem_rd_en   = cmd.setup;
   assign mem_rd_addr = rd_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
         rsp_strobe_ff <= cmd.draw_done || cmd.read_reply;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_read_ff <= (req_data.cmd == CMD_READ);
         rd_addr_ff <= rd_addr_in;
         rd_ok_ff   <= rd_ok_in;
         x_ff       <= req_data.x_start;
         y_ff       <= req_data.y_start;
         dx_ff      <= {req_data.x_end[COORD_W-1], req_data.x_end}
                       - {req_data.x_start[COORD_W-1], req_data.x_start};
         dy_ff      <= {req_data.y_end[COORD_W-1], req_data.y_end}
                       - {req_data.y_start[COORD_W-1], req_data.y_start};
      end
      if (cmd.setup) begin
         d_ff       <= d_init;
         inc_s_ff   <= inc_s_init;
         inc_d_ff   <= inc_d_init;
         cond_ff    <= cond_init;
         x_major_ff <= x_major_init;
         x_neg_ff   <= dx_neg;
         y_neg_ff   <= dy_neg;
         cnt_ff     <= cnt_init;
      end
      if (cmd.step && (cnt_ff != '0)) begin
         x_ff   <= x_next;
         y_ff   <= y_next;
         d_ff   <= d_next;
         cnt_ff <= cnt_ff - COORD_W'(1);
      end
      if (cmd.draw_done) begin
         rsp_ff.is_read_reply <= 1'b0;
         rsp_ff.pixel_lit     <= 1'b0;
      end else if (cmd.read_reply) begin
         rsp_ff.is_read_reply <= 1'b1;
         rsp_ff.pixel_lit     <= mem_rd_data && rd_ok_ff;
      end
   end

   assign status.clear_last = &clr_ff;
   assign status.step_last  = (cnt_ff == '0);
   assign status.is_read    = is_read_ff;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== rtl/core/midpoint_line_rasterizer_top.sv =====
// Top level of the midpoint line rasterizer: register port, controller, datapath, frame store.
// Depends on mlr_pkg, mlr_ctrl, mlr_datapath and mlr_frame_store.
`timescale 1ns / 1ps

// After reset the frame store is cleared one pixel per cycle; busy stays high over that pass
// and the register port works throughout. A command word is taken when start is high while
// busy is low. A draw keeps the block busy while the stepper lights one pixel per cycle
// through the single write port of the store, skipping pixels outside the active area; a
// read keeps it busy through the setup state, which does the registered read of the store,
// and the reply state. rsp_strobe marks the single response word on rsp_data for one cycle,
// in the first cycle in which busy is low, and cannot be held off. The next command can be
// taken in that same cycle. Registers: active_width at byte address 0 and active_height at
// 4, 9 bits each, both reset to 256.

module midpoint_line_rasterizer_top
   import mlr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_strobe,
   output rsp_type            rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   logic [CFG_W-1:0] active_width_ff;
   logic [CFG_W-1:0] active_height_ff;
   reg_index_type    csr_index;
   logic             csr_write;

   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_width_ff  <= ACTIVE_SIZE_RESET;
         active_height_ff <= ACTIVE_SIZE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ACTIVE_WIDTH:  active_width_ff  <= pwdata[CFG_W-1:0];
            REG_ACTIVE_HEIGHT: active_height_ff <= pwdata[CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ACTIVE_WIDTH:  prdata = {{(PDATA_W-CFG_W){1'b0}}, active_width_ff};
         REG_ACTIVE_HEIGHT: prdata = {{(PDATA_W-CFG_W){1'b0}}, active_height_ff};
         default:           prdata = '0;
      endcase
   end

   ctrl_cmd_type      cmd;
   dp_status_type     status;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic              mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic              mem_rd_data;

   mlr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   mlr_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_data      (req_data),
      .active_width  (active_width_ff),
      .active_height (active_height_ff),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data)
   );

   mlr_frame_store u_frame_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

`ifndef NO_ASSERTIONS
   // A response word only appears once the block has gone idle.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response word while busy");

   // An accepted command always keeps the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a command");

   // Each command gives a single response word, never two in a row.
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back response words");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for midpoint_line_rasterizer_top: draw and read command words,
// a shadow pixel store with its own line stepper, and APB writes and read-back checks of the active area.
// Depends on mlr_pkg and the RTL of the rasterizer.

module tb_top;
   import mlr_pkg::*;

   // The limit must cover the clear pass after reset, which alone runs without progress.
   localparam int WATCHDOG_LIMIT = 200000;

   logic               clock   = 1'b0;
   logic               reset   = 1'b1;
   logic               start   = 1'b0;
   logic               busy;
   req_type            req_data = '0;
   logic               rsp_strobe;
   rsp_type            rsp_data;
   logic               psel    = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite  = 1'b0;
   logic [PADDR_W-1:0] paddr   = '0;
   logic [PDATA_W-1:0] pwdata  = '0;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   midpoint_line_rasterizer_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   req_type pending_words[$];
   rsp_type expected_replies[$];
   int      send_idle_pct = 0;
   logic    item_taken = 1'b0;
   int      mismatch_count = 0;
   int      draws_checked = 0;
   int      reads_checked = 0;
   int      lit_seen = 0;
   int      stall_cycles = 0;

   // Shadow of the frame store and of the active-area registers.
   bit lit_model [0:MAX_HEIGHT-1][0:MAX_WIDTH-1];
   int model_width  = 256;
   int model_height = 256;

   // Endpoints of the latest generated draw; reads aim near this line.
   int recent_x0 = 0, recent_y0 = 0, recent_x1 = 0, recent_y1 = 0;

   function automatic void light_pixel(int x, int y);
      if (x >= 0 && y >= 0 && x < model_width && y < model_height &&
          x < MAX_WIDTH && y < MAX_HEIGHT)
         lit_model[y][x] = 1'b1;
   endfunction

   // Steps a doubled midpoint decision value along the major axis; axis lines are filled directly.
   function automatic void rasterize_segment(int x0, int y0, int x1, int y1);
      int dx, dy, ax, ay, x, y, dec, lo, hi;
      dx = x1 - x0;
      dy = y1 - y0;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      x = x0;
      y = y0;
      if (dy == 0) begin
         lo = (x0 < x1) ? x0 : x1;
         hi = (x0 < x1) ? x1 : x0;
         for (int i = lo; i <= hi; i++) light_pixel(i, y0);
      end else if (dx == 0) begin
         lo = (y0 < y1) ? y0 : y1;
         hi = (y0 < y1) ? y1 : y0;
         for (int i = lo; i <= hi; i++) light_pixel(x0, i);
      end else begin
         light_pixel(x, y);
         if (dx > 0 && dy > 0 && ax >= ay) begin
            dec = 2 * dy - dx;
            while (x < x1) begin
               if (dec > 0) begin x++; y++; dec += 2 * (dy - dx); end
               else begin x++; dec += 2 * dy; end
               light_pixel(x, y);
            end
         end else if (dx > 0 && dy > 0) begin
            dec = dy - 2 * dx;
            while (y < y1) begin
               if (dec >= 0) begin y++; dec -= 2 * dx; end
               else begin x++; y++; dec += 2 * (dy - dx); end
               light_pixel(x, y);
            end
         end else if (dx < 0 && dy > 0 && ay > ax) begin
            dec = -dy - 2 * dx;
            while (y < y1) begin
               if (dec <= 0) begin y++; dec -= 2 * dx; end
               else begin x--; y++; dec -= 2 * (dy + dx); end
               light_pixel(x, y);
            end
         end else if (dx < 0 && dy > 0) begin
            dec = -2 * dy - dx;
            while (x > x1) begin
               if (dec >= 0) begin x--; dec -= 2 * dy; end
               else begin x--; y++; dec -= 2 * (dy + dx); end
               light_pixel(x, y);
            end
         end else if (dx < 0 && ax >= ay) begin
            dec = -2 * dy + dx;
            while (x > x1) begin
               if (dec <= 0) begin x--; dec -= 2 * dy; end
               else begin x--; y--; dec -= 2 * (dy - dx); end
               light_pixel(x, y);
            end
         end else if (dx < 0) begin
            dec = -dy + 2 * dx;
            while (y > y1) begin
               if (dec > 0) begin y--; dec += 2 * dx; end
               else begin x--; y--; dec -= 2 * (dy - dx); end
               light_pixel(x, y);
            end
         end else if (ay > ax) begin
            dec = dy + 2 * dx;
            while (y > y1) begin
               if (dec <= 0) begin y--; dec += 2 * dx; end
               else begin x++; y--; dec += 2 * (dy + dx); end
               light_pixel(x, y);
            end
         end else begin
            dec = 2 * dy + dx;
            while (x < x1) begin
               if (dec >= 0) begin x++; dec += 2 * dy; end
               else begin x++; y--; dec += 2 * (dy + dx); end
               light_pixel(x, y);
            end
         end
      end
   endfunction

   function automatic rsp_type predict_reply(req_type w);
      rsp_type r;
      r = '0;
      if (w.cmd == CMD_READ) begin
         r.is_read_reply = 1'b1;
         r.pixel_lit = lit_model[w.read_row][w.read_col];
      end else begin
         rasterize_segment(int'($signed(w.x_start)), int'($signed(w.y_start)),
                           int'($signed(w.x_end)), int'($signed(w.y_end)));
      end
      return r;
   endfunction

   // Read fields of a draw carry random junk, as do endpoint fields of a read.
   function automatic req_type draw_word(int x0, int y0, int x1, int y1);
      req_type w;
      w = '0;
      w.cmd      = CMD_DRAW;
      w.x_start  = x0[COORD_W-1:0];
      w.y_start  = y0[COORD_W-1:0];
      w.x_end    = x1[COORD_W-1:0];
      w.y_end    = y1[COORD_W-1:0];
      w.read_col = RD_POS_W'($urandom);
      w.read_row = RD_POS_W'($urandom);
      recent_x0 = x0;
      recent_y0 = y0;
      recent_x1 = x1;
      recent_y1 = y1;
      return w;
   endfunction

   function automatic req_type read_word(int col, int row);
      req_type w;
      w = '0;
      w.cmd      = CMD_READ;
      w.x_start  = COORD_W'($urandom);
      w.y_start  = COORD_W'($urandom);
      w.x_end    = COORD_W'($urandom);
      w.y_end    = COORD_W'($urandom);
      w.read_col = col[RD_POS_W-1:0];
      w.read_row = row[RD_POS_W-1:0];
      return w;
   endfunction

   function automatic int any_coord();
      return int'($urandom_range(4095)) - 2048;
   endfunction

   function automatic int clamp_pos(int v);
      return (v < 0) ? 0 : ((v > 255) ? 255 : v);
   endfunction

   // Mostly short lines near the screen so the run stays fast; a few span the whole range.
   function automatic req_type random_draw();
      int kind, shape, span, x0, y0, dx, dy;
      kind = $urandom_range(99);
      if (kind < 4) return draw_word(any_coord(), any_coord(), any_coord(), any_coord());
      span = (kind < 14) ? 300 : 24;
      x0 = int'($urandom_range(285)) - 15;
      y0 = int'($urandom_range(285)) - 15;
      dx = int'($urandom_range(2 * span)) - span;
      dy = int'($urandom_range(2 * span)) - span;
      shape = $urandom_range(9);
      if (shape == 0) dy = 0;
      else if (shape == 1) dx = 0;
      else if (shape == 2) dy = ($urandom_range(1) == 1) ? dx : -dx;
      return draw_word(x0, y0, x0 + dx, y0 + dy);
   endfunction

   function automatic req_type random_read();
      int t, col, row;
      if ($urandom_range(9) < 7) begin
         t   = $urandom_range(16);
         col = recent_x0 + (recent_x1 - recent_x0) * t / 16 + int'($urandom_range(2)) - 1;
         row = recent_y0 + (recent_y1 - recent_y0) * t / 16 + int'($urandom_range(2)) - 1;
         return read_word(clamp_pos(col), clamp_pos(row));
      end
      return read_word($urandom_range(255), $urandom_range(255));
   endfunction

   // Command driver: a word stays on the port until it is taken.
   always @(negedge clock) begin
      if (!start || item_taken) begin
         if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            start    <= 1'b1;
            req_data <= pending_words.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Response checker and predictor. Replies are checked before the new word is predicted.
   always @(posedge clock) begin
      rsp_type want;
      item_taken <= start && !busy;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_replies.size() == 0) begin
               mismatch_count++;
               $display("%0t: reply word expected none got %b", $time, rsp_data);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_data.is_read_reply !== want.is_read_reply) begin
                  mismatch_count++;
                  $display("%0t: is_read_reply expected %b got %b", $time,
                           want.is_read_reply, rsp_data.is_read_reply);
               end
               if (rsp_data.pixel_lit !== want.pixel_lit) begin
                  mismatch_count++;
                  $display("%0t: pixel_lit expected %b got %b", $time,
                           want.pixel_lit, rsp_data.pixel_lit);
               end
               if (want.is_read_reply) reads_checked++;
               else draws_checked++;
               if (want.pixel_lit) lit_seen++;
            end
         end
         if (start && !busy) expected_replies.push_back(predict_reply(req_data));
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic csr_write(reg_index_type idx, int value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PADDR_W'(4 * int'(idx));
      pwdata  <= PDATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (idx == REG_ACTIVE_WIDTH) model_width = value & 'h1FF;
      else model_height = value & 'h1FF;
   endtask

   task automatic csr_check(reg_index_type idx, int value);
      logic [CFG_W-1:0] got;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= PADDR_W'(4 * int'(idx));
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      got = prdata[CFG_W-1:0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== value[CFG_W-1:0]) begin
         mismatch_count++;
         $display("%0t: register %s expected %0d got %0d", $time, idx.name(),
                  value[CFG_W-1:0], got);
      end
   endtask

   task automatic set_active_area(int width, int height);
      csr_write(REG_ACTIVE_WIDTH, width);
      csr_write(REG_ACTIVE_HEIGHT, height);
      csr_check(REG_ACTIVE_WIDTH, width);
      csr_check(REG_ACTIVE_HEIGHT, height);
   endtask

   // Holds off until every queued word is taken and every reply has come back.
   // Checked at the rising edge, where the driver's queue and start are settled.
   task automatic settle();
      do @(posedge clock);
      while (pending_words.size() != 0 || expected_replies.size() != 0 || start);
   endtask

   // A phase queues a random mix of draws and reads; most reads probe pixels on or near the latest line.
   task automatic run_phase(int idle_pct, int width, int height, int count);
      settle();
      send_idle_pct = idle_pct;
      set_active_area(width, height);
      repeat (count) begin
         if ($urandom_range(99) < 45) pending_words.push_back(random_draw());
         else pending_words.push_back(random_read());
      end
   endtask

   initial begin
      int oct_dx[8] = '{20, 7, -7, -20, -20, -7, 7, 20};
      int oct_dy[8] = '{7, 20, 20, 7, -7, -20, -20, -7};
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed part with an oversized area, which the store size limits.
      set_active_area(511, 511);
      pending_words.push_back(read_word(0, 0));
      pending_words.push_back(draw_word(5, 5, 5, 5));
      pending_words.push_back(read_word(5, 5));
      pending_words.push_back(draw_word(10, 20, 0, 20));
      pending_words.push_back(read_word(0, 20));
      pending_words.push_back(read_word(10, 20));
      pending_words.push_back(draw_word(30, 40, 30, 10));
      pending_words.push_back(read_word(30, 10));
      for (int i = 0; i < 8; i++)
         pending_words.push_back(draw_word(128, 128, 128 + oct_dx[i], 128 + oct_dy[i]));
      // Equal deltas go to the x-major octant.
      pending_words.push_back(draw_word(128, 128, 137, 137));
      pending_words.push_back(draw_word(128, 128, 119, 137));
      pending_words.push_back(read_word(137, 137));
      pending_words.push_back(draw_word(-2048, -2048, 2047, 2047));
      pending_words.push_back(draw_word(-2048, 255, 2047, 255));
      pending_words.push_back(read_word(255, 255));
      pending_words.push_back(read_word(200, 200));

      run_phase(16, 180, 97, 200);
      run_phase(16, 0, 511, 40);
      run_phase(59, 1, 1, 40);
      run_phase(59, 256, 256, 150);
      run_phase(0, $urandom_range(1, 256), $urandom_range(1, 256), 100);
      run_phase(0, 511, 300, 100);

      settle();
      repeat (8) @(negedge clock);
      $display("Checked %0d draws and %0d pixel reads (%0d lit) over seven active-area settings.",
               draws_checked, reads_checked, lit_seen);
      if (mismatch_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
